>>> design/grpt_pkg.sv
// Shared types and constants for the Gaussian row-pair triangulator.
// Holds the triangle item record and the remainder unit status struct.
// No dependencies; used by grpt_rem and gaussian_row_pair_triangulator_core.
package grpt_pkg;

	// width of each vertex index field on the output item
	localparam int OUT_BITS = 32;

	// output triangle queue geometry
	localparam int FIFO_DEPTH    = 4;
	localparam int FIFO_PTR_BITS = 2;
	localparam int FIFO_CNT_BITS = 3;

	// one triangle item as delivered on the output channel
	typedef struct packed {
		logic [OUT_BITS-1:0] vertex_a;
		logic [OUT_BITS-1:0] vertex_b;
		logic [OUT_BITS-1:0] vertex_c;
		logic                pair_done;
		logic                step_last;
		logic                tie_error;
	} tri_t;

	// status of the iterative remainder unit
	typedef struct packed {
		logic busy;
		logic done;
	} rem_stat_t;

endpackage

>>> design/grpt_rem.sv
// Iterative remainder unit: reduces two row positions modulo their row counts.
// Restoring scheme, one dividend bit per cycle, both lanes share one counter.
// Depends on grpt_pkg (rem_stat_t).
module grpt_rem #(
	parameter int W = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic                 clear,
	input  logic [W-1:0]         num1,
	input  logic [W-1:0]         den1,
	input  logic [W-1:0]         num2,
	input  logic [W-1:0]         den2,
	output logic [W-1:0]         rem1,
	output logic [W-1:0]         rem2,
	output grpt_pkg::rem_stat_t  stat
);

	localparam int CW = $clog2(W + 1);

	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [W-1:0]  d1_q, d2_q;
	logic [W-1:0]  r1_q, r2_q;
	logic [W:0]    t1, t2;
	logic [W-1:0]  nr1, nr2;

	// one restoring step per lane: shift in next dividend bit, subtract if it fits
	always_comb begin
		t1  = {r1_q, d1_q[W-1]};
		t2  = {r2_q, d2_q[W-1]};
		nr1 = (t1 >= {1'b0, den1}) ? W'(t1 - {1'b0, den1}) : W'(t1);
		nr2 = (t2 >= {1'b0, den2}) ? W'(t2 - {1'b0, den2}) : W'(t2);
	end

	// control: start loads, busy counts down W steps, done holds until cleared
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CW'(W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CW'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else if (clear) begin
			done_q <= 1'b0;
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (start) begin
			d1_q <= num1;
			d2_q <= num2;
			r1_q <= '0;
			r2_q <= '0;
		end else if (busy_q) begin
			d1_q <= {d1_q[W-2:0], 1'b0};
			d2_q <= {d2_q[W-2:0], 1'b0};
			r1_q <= nr1;
			r2_q <= nr2;
		end
	end

	assign rem1      = r1_q;
	assign rem2      = r2_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

>>> design/gaussian_row_pair_triangulator_core.sv
// Gaussian row-pair triangulator: one step item in, one or two triangle items out.
// Input register, then output queue; a triangle is valid once its step is queued.
// One step per cycle unless the remainder unit or a full queue stalls; a two-triangle
// step leaves as two items. A position past its row count (counts changed mid-pair)
// waits on the remainder unit. Reset: positions 1, row offset 0, output queue empty.
module gaussian_row_pair_triangulator_core #(
	parameter int ROW_LEN_BITS = 16,
	parameter int INDEX_BITS   = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          restart,
	input  logic [ROW_LEN_BITS-1:0]       lower_len,
	input  logic [ROW_LEN_BITS-1:0]       upper_len,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [grpt_pkg::OUT_BITS-1:0] vertex_a,
	output logic [grpt_pkg::OUT_BITS-1:0] vertex_b,
	output logic [grpt_pkg::OUT_BITS-1:0] vertex_c,
	output logic                          pair_done,
	output logic                          step_last,
	output logic                          tie_error
);

	localparam int L  = ROW_LEN_BITS;
	localparam int I  = INDEX_BITS;
	localparam int P  = 2 * L;
	localparam int OB = grpt_pkg::OUT_BITS;
	localparam int FD = grpt_pkg::FIFO_DEPTH;
	localparam int PB = grpt_pkg::FIFO_PTR_BITS;
	localparam int CB = grpt_pkg::FIFO_CNT_BITS;

	// input stage
	logic         valid_s1;
	logic         restart_s1;
	logic [L-1:0] n1_s1, n2_s1;

	// walk state
	logic [L-1:0] lower_pos_q, upper_pos_q;
	logic [I-1:0] row_offset_q;

	// step datapath
	logic [L-1:0] j1, j2, r1, r2, rem1, rem2, wp1, wp2, np1, np2;
	logic [I-1:0] roff, off1, off2;
	logic         need1, need2, need, s1_ready, s1_adv, room;
	grpt_pkg::rem_stat_t rem_stat;
	logic         rem_start;
	logic [P-1:0] pc0, pc1, pn0, pn1;
	logic [P:0]   dc, dn;
	logic         dc_pos, dc_neg, dc_zero, dn_pos, dn_neg;
	logic         adv_u, adv_l;
	logic [I-1:0] s_l, s_ln1, s_ul, s_un1, s_u, s_un2, s_j1n, s_j2n;
	logic [L-1:0] j1n, j2n, nl, nu;
	logic         two, fin;
	grpt_pkg::tri_t t0, t1;

	// output queue
	grpt_pkg::tri_t mem [FD];
	logic [PB-1:0]  wr_q, rd_q;
	logic [CB-1:0]  count_q;
	logic           pop;
	grpt_pkg::tri_t head;

	function automatic grpt_pkg::tri_t mk_tri(logic [I-1:0] a, logic [I-1:0] b,
			logic [I-1:0] c, logic d, logic l, logic t);
		grpt_pkg::tri_t r;
		r.vertex_a  = OB'(a);
		r.vertex_b  = OB'(b);
		r.vertex_c  = OB'(c);
		r.pair_done = d;
		r.step_last = l;
		r.tie_error = t;
		return r;
	endfunction

	// input register; a zero count is taken as one
	assign in_stall = valid_s1 && !s1_adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			restart_s1 <= restart;
			n1_s1      <= (lower_len == '0) ? L'(1) : lower_len;
			n2_s1      <= (upper_len == '0) ? L'(1) : upper_len;
		end
	end

	// effective state for this step, restart applied
	assign j1   = restart_s1 ? L'(1) : lower_pos_q;
	assign j2   = restart_s1 ? L'(1) : upper_pos_q;
	assign roff = restart_s1 ? '0 : row_offset_q;
	assign off1 = roff - I'(1);
	assign off2 = roff + I'(n1_s1) - I'(1);

	// positions beyond the row count go through the remainder unit
	assign need1     = j1 > n1_s1;
	assign need2     = j2 > n2_s1;
	assign need      = need1 || need2;
	assign rem_start = valid_s1 && need && !rem_stat.busy && !rem_stat.done;
	assign s1_ready  = !need || rem_stat.done;
	assign room      = count_q <= CB'(FD - 2);
	assign s1_adv    = valid_s1 && s1_ready && room;

	grpt_rem #(
		.W(L)
	) u_rem (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (rem_start),
		.clear  (s1_adv),
		.num1   (j1),
		.den1   (n1_s1),
		.num2   (j2),
		.den2   (n2_s1),
		.rem1   (rem1),
		.rem2   (rem2),
		.stat   (rem_stat)
	);

	// position modulo count, previous and next wrapped positions
	assign r1  = need ? rem1 : ((j1 == n1_s1) ? '0 : j1);
	assign r2  = need ? rem2 : ((j2 == n2_s1) ? '0 : j2);
	assign wp1 = (r1 == '0) ? n1_s1 - L'(1) : r1 - L'(1);
	assign wp2 = (r2 == '0) ? n2_s1 - L'(1) : r2 - L'(1);
	assign np1 = r1 + L'(1);
	assign np2 = r2 + L'(1);

	// cross-multiplied longitude differences, current and next points
	assign pc0 = P'(wp1) * P'(n2_s1);
	assign pc1 = P'(wp2) * P'(n1_s1);
	assign pn0 = P'(r1) * P'(n2_s1);
	assign pn1 = P'(r2) * P'(n1_s1);
	assign dc  = {1'b0, pc0} - {1'b0, pc1};
	assign dn  = {1'b0, pn0} - {1'b0, pn1};

	assign dc_zero = (pc0 == pc1);
	assign dc_neg  = dc[P];
	assign dc_pos  = !dc_zero && !dc_neg;
	assign dn_neg  = dn[P];
	assign dn_pos  = (pn0 != pn1) && !dn_neg;
	assign adv_u   = dc_pos || (dc_zero && dn_pos);
	assign adv_l   = dc_neg || (dc_zero && dn_neg);

	// global vertex indices
	assign s_l   = off1 + I'(j1);
	assign s_ln1 = off1 + I'(np1);
	assign s_ul  = off2 + I'(j1);
	assign s_un1 = off2 + I'(np1);
	assign s_u   = off2 + I'(j2);
	assign s_un2 = off2 + I'(np2);

	assign j1n   = adv_l ? np1 : j1;
	assign j2n   = adv_u ? np2 : j2;
	assign s_j1n = adv_l ? s_ln1 : s_l;
	assign s_j2n = adv_u ? s_un2 : s_u;

	// triangles of this step and the next walk state
	always_comb begin
		t0  = mk_tri(s_l, s_u, adv_u ? s_un2 : s_ln1, 1'b0, 1'b1, 1'b0);
		t1  = t0;
		two = 1'b0;
		fin = 1'b0;
		nl  = j1n;
		nu  = j2n;
		if (n1_s1 == n2_s1) begin
			// equal rows: two triangles of one quad
			t0  = mk_tri(s_l, s_ul, s_un1, 1'b0, 1'b0, 1'b0);
			t1  = mk_tri(s_un1, s_ln1, s_l, j1 >= n1_s1, 1'b1, 1'b0);
			two = 1'b1;
			fin = j1 >= n1_s1;
			nl  = j1 + L'(1);
			nu  = j1 + L'(1);
		end else if (adv_u || adv_l) begin
			if (j1n == L'(1) && j2n == n2_s1) begin
				// closing triangle back to the upper row start
				t0.step_last = 1'b0;
				t1  = mk_tri(s_j1n, s_j2n, roff + I'(n1_s1), 1'b1, 1'b1, 1'b0);
				two = 1'b1;
				fin = 1'b1;
			end else if (j1n == n1_s1 && j2n == L'(1)) begin
				// closing triangle back to the lower row start
				t0.step_last = 1'b0;
				t1  = mk_tri(s_j1n, s_j2n, roff, 1'b1, 1'b1, 1'b0);
				two = 1'b1;
				fin = 1'b1;
			end
		end else begin
			// both differences zero: flag and abandon the pair
			t0  = mk_tri('0, '0, '0, 1'b1, 1'b1, 1'b1);
			fin = 1'b1;
		end
	end

	// walk state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lower_pos_q  <= L'(1);
			upper_pos_q  <= L'(1);
			row_offset_q <= '0;
		end else if (s1_adv) begin
			if (fin) begin
				lower_pos_q  <= L'(1);
				upper_pos_q  <= L'(1);
				row_offset_q <= roff + I'(n1_s1);
			end else begin
				lower_pos_q  <= nl;
				upper_pos_q  <= nu;
				row_offset_q <= roff;
			end
		end
	end

	// output queue: push one or two items, pop one
	assign pop = out_valid && !out_stall;

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			mem[wr_q] <= t0;
			if (two) begin
				mem[PB'(wr_q + 1'b1)] <= t1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (s1_adv) begin
				wr_q <= wr_q + (two ? PB'(2) : PB'(1));
			end
			if (pop) begin
				rd_q <= rd_q + PB'(1);
			end
			count_q <= count_q + (s1_adv ? (two ? CB'(2) : CB'(1)) : CB'(0))
				- (pop ? CB'(1) : CB'(0));
		end
	end

	assign head      = mem[rd_q];
	assign out_valid = count_q != '0;
	assign vertex_a  = head.vertex_a;
	assign vertex_b  = head.vertex_b;
	assign vertex_c  = head.vertex_c;
	assign pair_done = head.pair_done;
	assign step_last = head.step_last;
	assign tie_error = head.tie_error;

endmodule
